[hdl/armor_target_selector_macros.svh]
// ----------------------------------------------------------------------------
// armor_target_selector_macros
// Assertion macros for the armor target selector, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ARMOR_TARGET_SELECTOR_MACROS_SVH
`define ARMOR_TARGET_SELECTOR_MACROS_SVH
`ifndef SYNTHESIS
`define ATS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ats assertion failed");
`define ATS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ats assertion failed");
`else
`define ATS_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define ATS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hdl/ats_pkg.sv]
// ----------------------------------------------------------------------------
// ats_pkg
// Types, constants and the arctangent step table of the armor target selector.
// ----------------------------------------------------------------------------
package ats_pkg;

  localparam int MAX_ARMORS_DEF = 4;
  localparam int YAW_FIELDS     = 4;
  localparam int CORDIC_STEPS   = 14;
  localparam int XW             = 27;  // CORDIC x/y width
  localparam int ZW             = 18;  // bearing width
  localparam int DW             = 18;  // offset width

  localparam logic signed [ZW-1:0] Q_PI         = 18'sd25736;
  localparam logic signed [ZW-1:0] Q_TWO_PI     = 18'sd51472;
  localparam logic signed [DW-1:0] FIRST_WINDOW = 18'sd8578;
  localparam logic [14:0]          ANGLE_RESET  = 15'd715;
  localparam logic [2:0]           LOCK_NONE    = 3'd7;

  localparam logic [7:0] REG_COMING  = 8'd0;
  localparam logic [7:0] REG_LEAVING = 8'd1;

  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_PAIR   = 2'd2;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [3:0][15:0]   yaw;
    logic [2:0]         n;        // armor count, clamped
    logic               rate_pos;
    logic               rate_neg;
    logic               outpost;
    logic [1:0]         mode;
  } item_t;

  typedef struct packed {
    logic [2:0] lock;
    logic       load;
  } back_sts_t;

  function automatic logic signed [ZW-1:0] step_angle(input logic [3:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      4'd0:    a = 18'sd6434;
      4'd1:    a = 18'sd3798;
      4'd2:    a = 18'sd2007;
      4'd3:    a = 18'sd1019;
      4'd4:    a = 18'sd511;
      4'd5:    a = 18'sd256;
      4'd6:    a = 18'sd128;
      4'd7:    a = 18'sd64;
      4'd8:    a = 18'sd32;
      4'd9:    a = 18'sd16;
      4'd10:   a = 18'sd8;
      4'd11:   a = 18'sd4;
      4'd12:   a = 18'sd2;
      4'd13:   a = 18'sd1;
      default: a = 18'sd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [DW-1:0] mag(input logic signed [DW-1:0] v);
    return v[DW-1] ? -v : v;
  endfunction

endpackage

[hdl/ats_front.sv]
// ----------------------------------------------------------------------------
// ats_front
// Accepts requests, clamps the armor count, reduces the rate to its sign and
// holds up to two classified items for the back end.
// ----------------------------------------------------------------------------
module ats_front #(
  parameter int MaxArmors = ats_pkg::MAX_ARMORS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_center_x,
  input  logic signed [15:0] in_center_y,
  input  logic signed [15:0] in_armor_yaw_0,
  input  logic signed [15:0] in_armor_yaw_1,
  input  logic signed [15:0] in_armor_yaw_2,
  input  logic signed [15:0] in_armor_yaw_3,
  input  logic [2:0]         in_armor_count,
  input  logic signed [15:0] in_yaw_rate,
  input  logic               in_is_outpost,
  input  logic [1:0]         in_mode,
  output logic               q_valid,
  output ats_pkg::item_t     q_item,
  input  logic               q_pop
);
  localparam int LimInt = (MaxArmors < ats_pkg::YAW_FIELDS) ? MaxArmors : ats_pkg::YAW_FIELDS;
  localparam logic [2:0] Lim = 3'(LimInt);

  ats_pkg::item_t mem_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;
  ats_pkg::item_t cls;
  logic           push;

  // classify the incoming request
  always_comb begin
    cls.cx       = in_center_x;
    cls.cy       = in_center_y;
    cls.yaw[0]   = in_armor_yaw_0;
    cls.yaw[1]   = in_armor_yaw_1;
    cls.yaw[2]   = in_armor_yaw_2;
    cls.yaw[3]   = in_armor_yaw_3;
    cls.n        = (in_armor_count > Lim) ? Lim : in_armor_count;
    cls.rate_pos = !in_yaw_rate[15] && (in_yaw_rate != 16'sd0);
    cls.rate_neg = in_yaw_rate[15];
    cls.outpost  = in_is_outpost;
    cls.mode     = in_mode;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule

[hdl/ats_back.sv]
// ----------------------------------------------------------------------------
// ats_back
// Takes the centre bearing with an iterative CORDIC, wraps armor offsets and
// selects the armor, keeping the sticky lock and the output register.
// ----------------------------------------------------------------------------
module ats_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ats_pkg::item_t     q_item,
  output logic               q_pop,
  input  logic [14:0]        coming,
  input  logic [14:0]        leaving,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_chosen_index,
  output ats_pkg::back_sts_t sts
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROT  = 2'd1;
  localparam logic [1:0] S_OFF  = 2'd2;
  localparam logic [1:0] S_SEL  = 2'd3;
  localparam int XW = ats_pkg::XW;
  localparam int ZW = ats_pkg::ZW;
  localparam int DW = ats_pkg::DW;

  logic [1:0]              st_r;
  logic [3:0]              step_r;
  ats_pkg::item_t          it_r;
  logic signed [XW-1:0]    x_r, y_r;
  logic signed [ZW-1:0]    z_r;
  logic                    origin_r;
  logic signed [DW-1:0]    d_r [4];
  logic [2:0]              lock_r;
  logic                    out_valid_r;
  logic [1:0]              out_idx_r;

  logic signed [XW-1:0]    x0, y0, sx, sy;
  logic signed [ZW-1:0]    z0, bear;
  logic signed [DW-1:0]    dw [4];
  logic [1:0]              chosen;
  logic [2:0]              lock_nxt;
  logic                    load;

  // pre-rotation into the right half-plane
  always_comb begin
    x0 = {{(XW-24){q_item.cx[15]}}, q_item.cx, 8'd0};
    y0 = {{(XW-24){q_item.cy[15]}}, q_item.cy, 8'd0};
    z0 = '0;
    if (x0 < 0) begin
      z0 = (y0 >= 0) ? ats_pkg::Q_PI : -ats_pkg::Q_PI;
      x0 = -x0;
      y0 = -y0;
    end
  end

  assign sx   = x_r >>> step_r;
  assign sy   = y_r >>> step_r;
  assign bear = origin_r ? '0 : z_r;

  // wrap each offset to (-pi, pi]
  always_comb begin
    logic signed [DW-1:0] t;
    for (int i = 0; i < 4; i++) begin
      t = $signed({{(DW-16){it_r.yaw[i][15]}}, it_r.yaw[i]}) - bear;
      if (t > ats_pkg::Q_PI) t = t - ats_pkg::Q_TWO_PI;
      else if (t <= -ats_pkg::Q_PI) t = t + ats_pkg::Q_TWO_PI;
      dw[i] = t;
    end
  end

  // armor selection
  always_comb begin
    logic [2:0]           cnt, a, b, best, sm;
    logic                 found;
    logic signed [DW-1:0] come, leave;
    cnt      = '0;
    a        = '0;
    b        = '0;
    best     = '0;
    sm       = '0;
    found    = 1'b0;
    come     = $signed({3'd0, coming});
    leave    = $signed({3'd0, leaving});
    chosen   = '0;
    lock_nxt = lock_r;
    if (it_r.mode == ats_pkg::MODE_SINGLE && !it_r.outpost && it_r.n != 3'd0) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < it_r.n && ats_pkg::mag(d_r[i]) <= ats_pkg::FIRST_WINDOW) begin
          if (cnt == 3'd0) a = 3'(i);
          else if (cnt == 3'd1) b = 3'(i);
          cnt = cnt + 3'd1;
        end
      end
      if (cnt > 3'd1) begin
        if (lock_r != a && lock_r != b)
          lock_nxt = (ats_pkg::mag(d_r[a[1:0]]) < ats_pkg::mag(d_r[b[1:0]])) ? a : b;
        chosen = lock_nxt[1:0];
      end else if (cnt == 3'd1) begin
        lock_nxt = ats_pkg::LOCK_NONE;
        chosen   = a[1:0];
      end
    end else if (it_r.n != 3'd0) begin
      if (!it_r.outpost) begin
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < it_r.n && ats_pkg::mag(d_r[i]) <= come) begin
            if ((it_r.rate_pos && d_r[i] < leave) || (it_r.rate_neg && d_r[i] > -leave)) begin
              best  = 3'(i);
              found = 1'b1;
            end
          end
        end
      end
      if (!found) begin
        for (int i = 1; i < 4; i++) begin
          if (3'(i) < it_r.n && ats_pkg::mag(d_r[i]) < ats_pkg::mag(d_r[sm[1:0]])) sm = 3'(i);
        end
        best = sm;
      end
      if (it_r.mode == ats_pkg::MODE_PAIR)
        best = (it_r.n >= 3'd3 && ats_pkg::mag(d_r[2]) < ats_pkg::mag(d_r[0])) ? 3'd2 : 3'd0;
      chosen = best[1:0];
    end
  end

  assign load  = (st_r == S_SEL) && (!out_valid_r || out_ready);
  assign q_pop = (st_r == S_IDLE) && q_valid;

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      it_r     <= q_item;
      x_r      <= x0;
      y_r      <= y0;
      z_r      <= z0;
      origin_r <= (q_item.cx == 16'sd0) && (q_item.cy == 16'sd0);
    end else if (st_r == S_ROT) begin
      if (y_r > 0) begin
        x_r <= x_r + sy;
        y_r <= y_r - sx;
        z_r <= z_r + ats_pkg::step_angle(step_r);
      end else begin
        x_r <= x_r - sy;
        y_r <= y_r + sx;
        z_r <= z_r - ats_pkg::step_angle(step_r);
      end
    end
    if (st_r == S_OFF) begin
      for (int i = 0; i < 4; i++) d_r[i] <= dw[i];
    end
    if (load) out_idx_r <= chosen;
  end

  // sequencer, lock and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      step_r      <= '0;
      lock_r      <= ats_pkg::LOCK_NONE;
      out_valid_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          step_r <= '0;
          if (q_valid) st_r <= S_ROT;
        end
        S_ROT: begin
          step_r <= step_r + 4'd1;
          if (step_r == 4'(ats_pkg::CORDIC_STEPS - 1)) st_r <= S_OFF;
        end
        S_OFF: st_r <= S_SEL;
        S_SEL: begin
          if (load) begin
            lock_r <= lock_nxt;
            st_r   <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
      // raise on a new result, drop once the held one is taken
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_index = out_idx_r;
  assign sts.lock         = lock_r;
  assign sts.load         = load;
endmodule

[hdl/armor_target_selector.sv]
// ----------------------------------------------------------------------------
// armor_target_selector
// Picks the armor of a tracked target to aim at from its centre bearing.
// ----------------------------------------------------------------------------
// Each item is loaded from the queue, then runs 14 iterations of the shared
// CORDIC unit for the centre bearing, a state that wraps the armor offsets
// and a state that selects, which waits until the output register is free.
// The back end takes no new item until the last is selected. A two-entry queue
// in front takes new requests while the back end works, and the output register
// holds a result until it is taken. Configuration writes are always accepted.
module armor_target_selector #(
  parameter int MaxArmors = ats_pkg::MAX_ARMORS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_center_x,
  input  logic signed [15:0] in_center_y,
  input  logic signed [15:0] in_armor_yaw_0,
  input  logic signed [15:0] in_armor_yaw_1,
  input  logic signed [15:0] in_armor_yaw_2,
  input  logic signed [15:0] in_armor_yaw_3,
  input  logic [2:0]         in_armor_count,
  input  logic signed [15:0] in_yaw_rate,
  input  logic               in_is_outpost,
  input  logic [1:0]         in_mode,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_chosen_index,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [14:0]        cfg_data
);
`include "armor_target_selector_macros.svh"

  logic               q_valid, q_pop;
  ats_pkg::item_t     q_item;
  ats_pkg::back_sts_t sts;
  logic [14:0]        coming_r, leaving_r;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coming_r  <= ats_pkg::ANGLE_RESET;
      leaving_r <= ats_pkg::ANGLE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == ats_pkg::REG_COMING) coming_r <= cfg_data;
      if (cfg_index == ats_pkg::REG_LEAVING) leaving_r <= cfg_data;
    end
  end

  ats_front #(.MaxArmors(MaxArmors)) u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_center_x, .in_center_y,
    .in_armor_yaw_0, .in_armor_yaw_1, .in_armor_yaw_2, .in_armor_yaw_3,
    .in_armor_count, .in_yaw_rate, .in_is_outpost, .in_mode,
    .q_valid, .q_item, .q_pop
  );

  ats_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .coming(coming_r), .leaving(leaving_r),
    .out_valid, .out_ready, .out_chosen_index, .sts
  );

  `ATS_ASSERT_SAME(a_lock_code, clk, rst_n, 1'b1, sts.lock < 3'd4 || sts.lock == ats_pkg::LOCK_NONE)
  `ATS_ASSERT_SAME(a_load_free, clk, rst_n, sts.load, !out_valid || out_ready)
  `ATS_ASSERT_NEXT(a_load_shows, clk, rst_n, sts.load, out_valid)
endmodule
